@@ rtl/core/gaps_pkg.sv @@
// ----------------------------------------------------------------------------
// gaps_pkg
// Shared constants, codes and types of the grid A* path search block.
// ----------------------------------------------------------------------------
package gaps_pkg;

    // grid geometry; a cell index is {col, row}, so MAX_ROWS is a power of two
    localparam int MAX_COLS = 32;
    localparam int MAX_ROWS = 32;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int CELL_W   = COL_W + ROW_W;
    localparam int NCELLS   = MAX_COLS * MAX_ROWS;
    localparam int CNT_W    = CELL_W + 1;
    localparam int AXIS_W   = (COL_W > ROW_W) ? COL_W : ROW_W;

    // costs
    localparam int G_W           = 16;
    localparam int H_W           = 16;
    localparam int F_W           = 17;
    localparam int COST_STRAIGHT = 10;
    localparam int COST_DIAG     = 14;

    // world to cell divider
    localparam int NUM_W = 36;
    localparam int DEN_W = 13;
    localparam int Q_W   = AXIS_W + 2;
    localparam int REM_W = DEN_W + Q_W;
    localparam int K_W   = $clog2(Q_W);

    // stream payload widths
    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 112;

    // item kinds
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_IGNORE = 2'd3;

    // result status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_PATH = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    // register indexes
    localparam logic [2:0] REG_GRID_X   = 3'd0;
    localparam logic [2:0] REG_GRID_Y   = 3'd1;
    localparam logic [2:0] REG_NODE     = 3'd2;
    localparam logic [2:0] REG_ORIGIN_X = 3'd3;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd4;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd5;

    typedef struct packed {
        logic        [5:0]  grid_size_x;
        logic        [5:0]  grid_size_y;
        logic        [11:0] node_size;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
    } t_cfg;

    // datapath commands, one per cycle
    typedef enum logic [4:0] {
        C_NONE, C_INIT, C_LATCH, C_DECODE, C_WAY, C_MAP_GO, C_MAP_WAIT,
        C_CLR, C_SEED, C_SEL, C_SCAN_A, C_SCAN_B, C_SCAN_C, C_POP,
        C_NB_A, C_NB_B, C_TR_A, C_TR_B, C_RESULT
    } t_cmd;

    // datapath status back to the controller
    typedef struct packed {
        logic [1:0] op;
        logic       way_hit;
        logic       div_done;
        logic       axis_last;
        logic       sweep_last;
        logic       live_zero;
        logic       scan_last;
        logic       is_target;
        logic       nb_skip;
        logic       nb_last;
        logic       trace_end;
        logic       out_free;
    } t_dp_stat;

endpackage

@@ rtl/core/grid_astar_path_search.sv @@
// ----------------------------------------------------------------------------
// grid_astar_path_search
// Grid A* path search with 8 neighbors and octile costs, APB registers.
// ----------------------------------------------------------------------------
// Cell write, waypoint read and op three go from decode to the result beat,
// which waits for a free output; an in-range read converts its cell first.
// Search: four axes mapped on a shared bit-serial divider, a flag clear,
// then per expansion a scan of every open-list entry (open-list read, then
// flag and node reads) and the neighbors, then the trace. One item at a time.
// Reset: walk map fill to walkable; no item accepted until done.
// ----------------------------------------------------------------------------
module grid_astar_path_search import gaps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input beat
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // cell_col[4:0] cell_row[9:5] walkable[10] start_x[42:11] start_y[74:43]
    // target_x[106:75] target_y[138:107] step_index[148:139]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op[1:0]
    input  logic [1:0]            s_axis_tuser,
    // result beat
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // path_length[10:0] way_x[42:11] way_y[74:43] way_z[106:75]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]            m_axis_tuser,
    // APB
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    t_cfg     r_cfg;
    t_cmd     w_cmd;
    t_dp_stat w_stat;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_size_x <= 6'd32;
            r_cfg.grid_size_y <= 6'd32;
            r_cfg.node_size   <= 12'd100;
            r_cfg.origin_x    <= '0;
            r_cfg.origin_y    <= '0;
            r_cfg.origin_z    <= '0;
        end else if (w_wr) begin
            case (paddr[4:2])
                REG_GRID_X:   r_cfg.grid_size_x <= pwdata[5:0];
                REG_GRID_Y:   r_cfg.grid_size_y <= pwdata[5:0];
                REG_NODE:     r_cfg.node_size   <= pwdata[11:0];
                REG_ORIGIN_X: r_cfg.origin_x    <= pwdata;
                REG_ORIGIN_Y: r_cfg.origin_y    <= pwdata;
                REG_ORIGIN_Z: r_cfg.origin_z    <= pwdata;
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (paddr[4:2])
            REG_GRID_X:   prdata = 32'(r_cfg.grid_size_x);
            REG_GRID_Y:   prdata = 32'(r_cfg.grid_size_y);
            REG_NODE:     prdata = 32'(r_cfg.node_size);
            REG_ORIGIN_X: prdata = r_cfg.origin_x;
            REG_ORIGIN_Y: prdata = r_cfg.origin_y;
            REG_ORIGIN_Z: prdata = r_cfg.origin_z;
            default:      prdata = '0;
        endcase
    end

    gaps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (w_stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    gaps_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cfg        (r_cfg),
        .i_in_data    (s_axis_tdata),
        .i_in_op      (s_axis_tuser),
        .o_stat       (w_stat),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .o_res_status (m_axis_tuser),
        .o_res_data   (m_axis_tdata)
    );

endmodule

@@ rtl/core/gaps_axis_div.sv @@
// ----------------------------------------------------------------------------
// gaps_axis_div
// Maps one world axis offset to a cell: floor(num / den), one quotient bit
// a cycle, saturated and clamped to 0..limit-1.
// ----------------------------------------------------------------------------
module gaps_axis_div import gaps_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic        [DEN_W-1:0] i_den,
    input  logic        [5:0]       i_limit,
    output logic                    o_done,
    output logic        [AXIS_W-1:0] o_cell
);

    logic             r_busy, r_done;
    logic [K_W-1:0]   r_k;
    logic [REM_W-1:0] r_rem;
    logic [Q_W-1:0]   r_q;
    logic [DEN_W-1:0] r_den;

    logic [NUM_W-1:0] w_num_u, w_top;
    logic             w_big;
    logic [REM_W-1:0] w_sub;

    // quotient at or above 2^Q_W only saturates
    assign w_num_u = i_num;
    assign w_top   = NUM_W'({i_den, {Q_W{1'b0}}});
    assign w_big   = w_num_u >= w_top;
    assign w_sub   = REM_W'(r_den) << r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            if (i_start) begin
                r_den <= i_den;
                if (i_num[NUM_W-1] || w_big) begin
                    // negative clamps to zero, too large saturates
                    r_q    <= i_num[NUM_W-1] ? '0 : '1;
                    r_done <= 1'b1;
                end else begin
                    r_q    <= '0;
                    r_rem  <= REM_W'(w_num_u);
                    r_k    <= K_W'(Q_W - 1);
                    r_busy <= 1'b1;
                    r_done <= 1'b0;
                end
            end else if (r_busy) begin
                // restoring step
                if (r_rem >= w_sub) begin
                    r_rem    <= r_rem - w_sub;
                    r_q[r_k] <= 1'b1;
                end
                if (r_k == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_k    <= r_k - 1'b1;
                    r_done <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    // clamp to the grid in use
    assign o_done = r_done;
    assign o_cell = (r_q >= Q_W'(i_limit)) ? AXIS_W'(i_limit - 6'd1) : AXIS_W'(r_q);

endmodule

@@ rtl/core/gaps_dp.sv @@
// ----------------------------------------------------------------------------
// gaps_dp
// Search datapath: walk map, flags, node costs, open list and path stores,
// cell mapping, scan compare, neighbor relax and result register.
// ----------------------------------------------------------------------------
module gaps_dp import gaps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  t_cfg                  i_cfg,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic [1:0]            i_in_op,
    output t_dp_stat              o_stat,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output logic [1:0]            o_res_status,
    output logic [OUT_DATA_W-1:0] o_res_data
);

    typedef struct packed {
        logic [G_W-1:0]    g;
        logic [H_W-1:0]    h;
        logic [CELL_W-1:0] par;
    } t_node;

    localparam logic [1:0] FLAG_OPEN   = 2'b01;
    localparam logic [1:0] FLAG_CLOSED = 2'b10;
    localparam logic [1:0] FLAG_NONE   = 2'b00;

    // octile distance between two cells
    function automatic logic [H_W-1:0] octile(input logic [CELL_W-1:0] a,
                                              input logic [CELL_W-1:0] b);
        logic [COL_W-1:0] dx;
        logic [ROW_W-1:0] dy;
        logic [H_W-1:0]   mx, mn;
        dx = (a[CELL_W-1:ROW_W] > b[CELL_W-1:ROW_W]) ?
             a[CELL_W-1:ROW_W] - b[CELL_W-1:ROW_W] : b[CELL_W-1:ROW_W] - a[CELL_W-1:ROW_W];
        dy = (a[ROW_W-1:0] > b[ROW_W-1:0]) ?
             a[ROW_W-1:0] - b[ROW_W-1:0] : b[ROW_W-1:0] - a[ROW_W-1:0];
        mx = (H_W'(dx) > H_W'(dy)) ? H_W'(dx) : H_W'(dy);
        mn = (H_W'(dx) > H_W'(dy)) ? H_W'(dy) : H_W'(dx);
        return H_W'(COST_DIAG) * mn + H_W'(COST_STRAIGHT) * (mx - mn);
    endfunction

    // memories
    logic                walk_mem [NCELLS];
    logic [1:0]          flag_mem [NCELLS];
    t_node               node_mem [NCELLS];
    logic [CELL_W-1:0]   open_mem [NCELLS];
    logic [CELL_W-1:0]   path_mem [NCELLS];

    logic                walk_we, r_walk_q, walk_wd;
    logic [CELL_W-1:0]   walk_wa, walk_ra;
    logic                flag_we;
    logic [1:0]          flag_wd, r_flag_q;
    logic [CELL_W-1:0]   flag_wa, flag_ra;
    logic                node_we;
    t_node               node_wd, r_node_q;
    logic [CELL_W-1:0]   node_wa, node_ra;
    logic                open_we;
    logic [CELL_W-1:0]   open_wa, open_ra, open_wd, r_open_q;
    logic                path_we;
    logic [CELL_W-1:0]   path_wa, path_ra, path_wd, r_path_q;

    // latched item
    logic [1:0]          r_op;
    logic [4:0]          r_col, r_row;
    logic                r_walk;
    logic signed [31:0]  r_sx, r_sy, r_tx, r_ty;
    logic [9:0]          r_step;

    // search state
    logic [1:0]          r_axis;
    logic [AXIS_W-1:0]   r_sc, r_sr, r_tc, r_tr;
    logic [CELL_W-1:0]   r_cnt, r_idx, r_best, r_cur, r_nb, r_trace;
    logic [CNT_W-1:0]    r_open_len, r_live, r_n, r_path_count;
    logic [G_W-1:0]      r_best_g, r_cur_g;
    logic [H_W-1:0]      r_best_h;
    logic [F_W-1:0]      r_best_f;
    logic                r_best_ok, r_diag;
    logic [3:0]          r_k;

    // result staging and output register
    logic [1:0]          r_st, r_o_st;
    logic signed [31:0]  r_wx, r_wy, r_wz, r_o_wx, r_o_wy, r_o_wz;
    logic [CNT_W-1:0]    r_o_len;
    logic                r_o_valid;

    // derived signals
    logic [5:0]          w_cols, w_rows;
    logic [11:0]         w_ns;
    logic signed [31:0]  w_pos, w_org;
    logic signed [33:0]  w_diff;
    logic signed [NUM_W-1:0] w_num;
    logic [5:0]          w_limit;
    logic                w_div_done;
    logic [AXIS_W-1:0]   w_div_cell;
    logic [CELL_W-1:0]   w_start, w_tgt, w_nb, w_path_addr;
    logic [1:0]          w_di, w_dj;
    logic [5:0]          w_nx_p, w_ny_p;
    logic                w_nb_skip, w_relax, w_better, w_trace_end, w_out_free, w_way_hit;
    logic [G_W-1:0]      w_ng;
    logic [F_W-1:0]      w_f;
    logic [4:0]          w_way_col, w_way_row;

    // grid size in use and spacing
    always_comb begin
        w_cols = (i_cfg.grid_size_x == '0) ? 6'd1 :
                 (i_cfg.grid_size_x > 6'(MAX_COLS)) ? 6'(MAX_COLS) : i_cfg.grid_size_x;
        w_rows = (i_cfg.grid_size_y == '0) ? 6'd1 :
                 (i_cfg.grid_size_y > 6'(MAX_ROWS)) ? 6'(MAX_ROWS) : i_cfg.grid_size_y;
        w_ns   = (i_cfg.node_size == '0) ? 12'd1 : i_cfg.node_size;
    end

    // divider operands: axes start x, start y, target x, target y
    always_comb begin
        unique case (r_axis)
            2'd0:    begin w_pos = r_sx; w_org = i_cfg.origin_x; w_limit = w_cols; end
            2'd1:    begin w_pos = r_sy; w_org = i_cfg.origin_y; w_limit = w_rows; end
            2'd2:    begin w_pos = r_tx; w_org = i_cfg.origin_x; w_limit = w_cols; end
            default: begin w_pos = r_ty; w_org = i_cfg.origin_y; w_limit = w_rows; end
        endcase
        w_diff = 34'(w_pos) - 34'(w_org);
        w_num  = (NUM_W'(w_diff) <<< 1) + NUM_W'({24'd0, w_ns});
    end

    gaps_axis_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd == C_MAP_GO),
        .i_num   (w_num),
        .i_den   ({w_ns, 1'b0}),
        .i_limit (w_limit),
        .o_done  (w_div_done),
        .o_cell  (w_div_cell)
    );

    assign w_start = {COL_W'(r_sc), ROW_W'(r_sr)};
    assign w_tgt   = {COL_W'(r_tc), ROW_W'(r_tr)};

    // neighbor offset: column outer, row inner
    always_comb begin
        w_di      = (r_k < 4'd3) ? 2'd0 : (r_k < 4'd6) ? 2'd1 : 2'd2;
        w_dj      = 2'(r_k - 4'(w_di) * 4'd3);
        w_nx_p    = 6'(r_cur[CELL_W-1:ROW_W]) + 6'(w_di);
        w_ny_p    = 6'(r_cur[ROW_W-1:0]) + 6'(w_dj);
        w_nb      = {COL_W'(w_nx_p - 6'd1), ROW_W'(w_ny_p - 6'd1)};
        w_nb_skip = (r_k == 4'd4) || (w_nx_p == '0) || (w_ny_p == '0) ||
                    ((w_nx_p - 6'd1) >= w_cols) || ((w_ny_p - 6'd1) >= w_rows);
    end

    // relax and scan compare
    always_comb begin
        w_ng     = r_cur_g + (r_diag ? G_W'(COST_DIAG) : G_W'(COST_STRAIGHT));
        w_relax  = !r_flag_q[1] && r_walk_q && (!r_flag_q[0] || (w_ng < r_node_q.g));
        w_f      = F_W'(r_node_q.g) + F_W'(r_node_q.h);
        w_better = r_flag_q[0] && (!r_best_ok || (w_f < r_best_f) ||
                   ((w_f == r_best_f) && (r_node_q.h < r_best_h)));
    end

    assign w_trace_end = (r_trace == w_start) || (r_n == CNT_W'(NCELLS));
    assign w_way_hit   = CNT_W'(r_step) < r_path_count;
    assign w_path_addr = CELL_W'(r_path_count - CNT_W'(1) - CNT_W'(r_step));
    assign w_out_free  = !r_o_valid || i_res_ready;
    assign w_way_col   = 5'(r_path_q[CELL_W-1:ROW_W]);
    assign w_way_row   = 5'(r_path_q[ROW_W-1:0]);

    // memory port control
    always_comb begin
        walk_we = 1'b0; walk_wa = r_cnt; walk_wd = 1'b1; walk_ra = w_nb;
        flag_we = 1'b0; flag_wa = r_cnt; flag_wd = FLAG_NONE; flag_ra = w_nb;
        node_we = 1'b0; node_wa = r_nb; node_ra = w_nb;
        node_wd = '{g: w_ng, h: octile(r_nb, w_tgt), par: r_cur};
        open_we = 1'b0; open_wa = r_open_len[CELL_W-1:0]; open_wd = r_nb; open_ra = r_idx;
        path_we = 1'b0; path_wa = r_n[CELL_W-1:0]; path_wd = r_trace; path_ra = w_path_addr;
        unique case (i_cmd)
            C_INIT: walk_we = 1'b1;
            C_DECODE: begin
                if (r_op == OP_WRITE) begin
                    walk_we = 1'b1;
                    walk_wa = {COL_W'(r_col), ROW_W'(r_row)};
                    walk_wd = r_walk;
                end
            end
            C_CLR: flag_we = 1'b1;
            C_SEED: begin
                flag_we = 1'b1; flag_wa = w_start; flag_wd = FLAG_OPEN;
                open_we = 1'b1; open_wa = '0; open_wd = w_start;
                node_we = 1'b1; node_wa = w_start;
                node_wd = '{g: '0, h: '0, par: w_start};
            end
            C_SCAN_B: begin
                flag_ra = r_open_q;
                node_ra = r_open_q;
            end
            C_POP: begin
                flag_we = 1'b1; flag_wa = r_best; flag_wd = FLAG_CLOSED;
            end
            C_NB_B: begin
                if (w_relax) begin
                    node_we = 1'b1;
                    if (!r_flag_q[0]) begin
                        flag_we = 1'b1; flag_wa = r_nb; flag_wd = FLAG_OPEN;
                        open_we = 1'b1;
                    end
                end
            end
            C_TR_A: begin
                node_ra = r_trace;
                path_we = !w_trace_end;
            end
            default: ;
        endcase
    end

    // memories, registered reads
    always_ff @(posedge i_clk) begin
        if (walk_we) walk_mem[walk_wa] <= walk_wd;
        r_walk_q <= walk_mem[walk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (flag_we) flag_mem[flag_wa] <= flag_wd;
        r_flag_q <= flag_mem[flag_ra];
    end

    always_ff @(posedge i_clk) begin
        if (node_we) node_mem[node_wa] <= node_wd;
        r_node_q <= node_mem[node_ra];
    end

    always_ff @(posedge i_clk) begin
        if (open_we) open_mem[open_wa] <= open_wd;
        r_open_q <= open_mem[open_ra];
    end

    always_ff @(posedge i_clk) begin
        if (path_we) path_mem[path_wa] <= path_wd;
        r_path_q <= path_mem[path_ra];
    end

    // item latch and search payload
    always_ff @(posedge i_clk) begin
        if (i_cmd == C_LATCH) begin
            r_op   <= i_in_op;
            r_col  <= i_in_data[4:0];
            r_row  <= i_in_data[9:5];
            r_walk <= i_in_data[10];
            r_sx   <= i_in_data[42:11];
            r_sy   <= i_in_data[74:43];
            r_tx   <= i_in_data[106:75];
            r_ty   <= i_in_data[138:107];
            r_step <= i_in_data[148:139];
        end
        if (i_cmd == C_MAP_WAIT && w_div_done) begin
            unique case (r_axis)
                2'd0:    r_sc <= w_div_cell;
                2'd1:    r_sr <= w_div_cell;
                2'd2:    r_tc <= w_div_cell;
                default: r_tr <= w_div_cell;
            endcase
        end
        if (i_cmd == C_SCAN_C && w_better) begin
            r_best   <= r_open_q;
            r_best_g <= r_node_q.g;
            r_best_h <= r_node_q.h;
            r_best_f <= w_f;
        end
        if (i_cmd == C_POP) begin
            r_cur   <= r_best;
            r_cur_g <= r_best_g;
            r_trace <= w_tgt;
        end
        if (i_cmd == C_NB_A) begin
            r_nb   <= w_nb;
            r_diag <= (w_di != 2'd1) && (w_dj != 2'd1);
        end
        if (i_cmd == C_TR_B) r_trace <= r_node_q.par;
        if (i_cmd == C_RESULT && w_out_free) begin
            r_o_st  <= r_st;
            r_o_len <= r_path_count;
            r_o_wx  <= r_wx;
            r_o_wy  <= r_wy;
            r_o_wz  <= r_wz;
        end
        // result staging
        unique case (i_cmd)
            C_DECODE: begin
                r_st <= (r_op == OP_READ && !w_way_hit) ? ST_RANGE : ST_OK;
                r_wx <= '0;
                r_wy <= '0;
                r_wz <= '0;
            end
            C_WAY: begin
                r_wx <= i_cfg.origin_x + 32'(w_way_col) * 32'(i_cfg.node_size);
                r_wy <= i_cfg.origin_y + 32'(w_way_row) * 32'(i_cfg.node_size);
                r_wz <= i_cfg.origin_z;
            end
            C_SEL: if (r_live == '0) r_st <= ST_NO_PATH;
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis       <= '0;
            r_cnt        <= '0;
            r_idx        <= '0;
            r_open_len   <= '0;
            r_live       <= '0;
            r_n          <= '0;
            r_path_count <= '0;
            r_best_ok    <= 1'b0;
            r_k          <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            // output beat: load wins over the drain of the previous one
            if (i_cmd == C_RESULT && w_out_free) r_o_valid <= 1'b1;
            else if (r_o_valid && i_res_ready)   r_o_valid <= 1'b0;
            unique case (i_cmd)
                C_INIT, C_CLR: r_cnt <= r_cnt + 1'b1;
                C_MAP_WAIT:    if (w_div_done) r_axis <= r_axis + 1'b1;
                C_SEED: begin
                    r_open_len   <= CNT_W'(1);
                    r_live       <= CNT_W'(1);
                    r_path_count <= '0;
                end
                C_SEL: begin
                    r_idx     <= '0;
                    r_best_ok <= 1'b0;
                end
                C_SCAN_C: begin
                    r_idx <= r_idx + 1'b1;
                    if (w_better) r_best_ok <= 1'b1;
                end
                C_POP: begin
                    r_live <= r_live - 1'b1;
                    r_k    <= '0;
                    r_n    <= '0;
                end
                C_NB_A: if (w_nb_skip) r_k <= r_k + 1'b1;
                C_NB_B: begin
                    r_k <= r_k + 1'b1;
                    if (w_relax && !r_flag_q[0]) begin
                        r_open_len <= r_open_len + 1'b1;
                        r_live     <= r_live + 1'b1;
                    end
                end
                C_TR_A: begin
                    if (w_trace_end) r_path_count <= r_n;
                    else r_n <= r_n + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // status to controller
    always_comb begin
        o_stat.op         = r_op;
        o_stat.way_hit    = w_way_hit;
        o_stat.div_done   = w_div_done;
        o_stat.axis_last  = (r_axis == 2'd3);
        o_stat.sweep_last = &r_cnt;
        o_stat.live_zero  = (r_live == '0);
        o_stat.scan_last  = ((CNT_W'(r_idx) + CNT_W'(1)) == r_open_len);
        o_stat.is_target  = (r_best == w_tgt);
        o_stat.nb_skip    = w_nb_skip;
        o_stat.nb_last    = (r_k == 4'd8);
        o_stat.trace_end  = w_trace_end;
        o_stat.out_free   = w_out_free;
    end

    assign o_res_valid  = r_o_valid;
    assign o_res_status = r_o_st;
    assign o_res_data   = {5'd0, r_o_wz, r_o_wy, r_o_wx, r_o_len};

endmodule

@@ rtl/core/gaps_ctrl.sv @@
// ----------------------------------------------------------------------------
// gaps_ctrl
// Controller state machine: map fill, item decode, cell mapping, flag clear,
// open list scan, neighbor expansion, path trace and result hand-off.
// ----------------------------------------------------------------------------
module gaps_ctrl import gaps_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_cmd     o_cmd
);

    typedef enum logic [17:0] {
        S_INIT     = 18'h00001,
        S_IDLE     = 18'h00002,
        S_DECODE   = 18'h00004,
        S_WAY      = 18'h00008,
        S_MAP_GO   = 18'h00010,
        S_MAP_WAIT = 18'h00020,
        S_CLR      = 18'h00040,
        S_SEED     = 18'h00080,
        S_SEL      = 18'h00100,
        S_SCAN_A   = 18'h00200,
        S_SCAN_B   = 18'h00400,
        S_SCAN_C   = 18'h00800,
        S_POP      = 18'h01000,
        S_NB_A     = 18'h02000,
        S_NB_B     = 18'h04000,
        S_TR_A     = 18'h08000,
        S_TR_B     = 18'h10000,
        S_RESULT   = 18'h20000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_INIT;
        else          r_state <= n_state;
    end

    // next state and command
    always_comb begin
        n_state    = r_state;
        o_cmd      = C_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd = C_INIT;
                if (i_stat.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd   = C_LATCH;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd = C_DECODE;
                if (i_stat.op == OP_SEARCH)                    n_state = S_MAP_GO;
                else if (i_stat.op == OP_READ && i_stat.way_hit) n_state = S_WAY;
                else                                           n_state = S_RESULT;
            end
            S_WAY: begin
                o_cmd   = C_WAY;
                n_state = S_RESULT;
            end
            S_MAP_GO: begin
                o_cmd   = C_MAP_GO;
                n_state = S_MAP_WAIT;
            end
            S_MAP_WAIT: begin
                o_cmd = C_MAP_WAIT;
                if (i_stat.div_done) n_state = i_stat.axis_last ? S_CLR : S_MAP_GO;
            end
            S_CLR: begin
                o_cmd = C_CLR;
                if (i_stat.sweep_last) n_state = S_SEED;
            end
            S_SEED: begin
                o_cmd   = C_SEED;
                n_state = S_SEL;
            end
            S_SEL: begin
                o_cmd   = C_SEL;
                n_state = i_stat.live_zero ? S_RESULT : S_SCAN_A;
            end
            S_SCAN_A: begin
                o_cmd   = C_SCAN_A;
                n_state = S_SCAN_B;
            end
            S_SCAN_B: begin
                o_cmd   = C_SCAN_B;
                n_state = S_SCAN_C;
            end
            S_SCAN_C: begin
                o_cmd   = C_SCAN_C;
                n_state = i_stat.scan_last ? S_POP : S_SCAN_A;
            end
            S_POP: begin
                o_cmd   = C_POP;
                n_state = i_stat.is_target ? S_TR_A : S_NB_A;
            end
            S_NB_A: begin
                o_cmd = C_NB_A;
                if (!i_stat.nb_skip)     n_state = S_NB_B;
                else if (i_stat.nb_last) n_state = S_SEL;
            end
            S_NB_B: begin
                o_cmd   = C_NB_B;
                n_state = i_stat.nb_last ? S_SEL : S_NB_A;
            end
            S_TR_A: begin
                o_cmd   = C_TR_A;
                n_state = i_stat.trace_end ? S_RESULT : S_TR_B;
            end
            S_TR_B: begin
                o_cmd   = C_TR_B;
                n_state = S_TR_A;
            end
            S_RESULT: begin
                o_cmd = C_RESULT;
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

endmodule

@@ tb/sv/tb_grid_astar_path_search.sv @@
// ----------------------------------------------------------------------------
// tb_grid_astar_path_search
// Drives cell writes, searches and waypoint reads through the stream port,
// changes the grid registers between phases over APB, and compares every
// result beat with a behavioral A* predictor kept in a scoreboard class.
// ----------------------------------------------------------------------------
module tb_grid_astar_path_search;
    import gaps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // expected result of one item
    typedef struct {
        logic [1:0]  status;
        logic [10:0] path_len;
        logic [31:0] wx, wy, wz;
    } t_res;

    // A* predictor and result queue
    class path_board;
        bit [5:0]   gx, gy;
        bit [11:0]  ns;
        bit [31:0]  ox, oy, oz;
        bit         walk[NCELLS];
        int         gc[NCELLS], hc[NCELLS], par[NCELLS];
        bit         opn[NCELLS], cls[NCELLS];
        int         olist[$];
        int         path[$];
        t_res       pending[$];
        int         errors;

        function void init();
            gx = 32; gy = 32; ns = 100; ox = 0; oy = 0; oz = 0;
            foreach (walk[i]) walk[i] = 1;
            path = {};
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_GRID_X:   gx = v[5:0];
                REG_GRID_Y:   gy = v[5:0];
                REG_NODE:     ns = v[11:0];
                REG_ORIGIN_X: ox = v;
                REG_ORIGIN_Y: oy = v;
                REG_ORIGIN_Z: oz = v;
                default: ;
            endcase
        endfunction

        function int lim(int v, int m);
            if (v < 1) return 1;
            if (v > m) return m;
            return v;
        endfunction

        // world to cell: floor((2*off + ns) / (2*ns)), clamped
        function int axis_cell(logic [31:0] pos, logic [31:0] org, int n);
            longint s, a, b, q;
            s = (ns == 0) ? 1 : ns;
            a = 2 * (longint'($signed(pos)) - longint'($signed(org))) + s;
            b = 2 * s;
            q = a / b;
            if ((a % b) != 0 && a < 0) q--;
            if (q < 0) q = 0;
            if (q > n - 1) q = n - 1;
            return int'(q);
        endfunction

        function int octile(int a, int b);
            int dx, dy;
            dx = a / MAX_ROWS - b / MAX_ROWS;
            dy = a % MAX_ROWS - b % MAX_ROWS;
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dx > dy) return COST_DIAG * dy + COST_STRAIGHT * (dx - dy);
            return COST_DIAG * dx + COST_STRAIGHT * (dy - dx);
        endfunction

        function bit run_search(int st, int tg, int cols, int rows);
            int best, cur, c, nx, ny, nb, ng;
            foreach (gc[i]) begin
                gc[i] = 0; hc[i] = 0; par[i] = 0; opn[i] = 0; cls[i] = 0;
            end
            olist = {st};
            path = {};
            opn[st] = 1;
            while (olist.size() > 0) begin
                best = 0;
                for (int i = 1; i < olist.size(); i++) begin
                    if (gc[olist[i]] + hc[olist[i]] < gc[olist[best]] + hc[olist[best]] ||
                        (gc[olist[i]] + hc[olist[i]] == gc[olist[best]] + hc[olist[best]]
                         && hc[olist[i]] < hc[olist[best]]))
                        best = i;
                end
                cur = olist[best];
                olist.delete(best);
                opn[cur] = 0;
                cls[cur] = 1;
                if (cur == tg) begin
                    c = tg;
                    while (c != st && path.size() < NCELLS) begin
                        path.push_front(c);
                        c = par[c];
                    end
                    return 1;
                end
                for (int dx = -1; dx <= 1; dx++) begin
                    for (int dy = -1; dy <= 1; dy++) begin
                        nx = cur / MAX_ROWS + dx;
                        ny = cur % MAX_ROWS + dy;
                        if (dx == 0 && dy == 0) continue;
                        if (nx < 0 || ny < 0 || nx >= cols || ny >= rows) continue;
                        nb = nx * MAX_ROWS + ny;
                        if (cls[nb] || !walk[nb]) continue;
                        ng = gc[cur] + octile(cur, nb);
                        if (ng < gc[nb] || !opn[nb]) begin
                            gc[nb] = ng;
                            hc[nb] = octile(nb, tg);
                            par[nb] = cur;
                            if (!opn[nb]) begin
                                opn[nb] = 1;
                                olist.push_back(nb);
                            end
                        end
                    end
                end
            end
            return 0;
        endfunction

        // note an accepted input beat
        function void note_item(logic [1:0] op, logic [IN_DATA_W-1:0] d);
            t_res r;
            int cols, rows, c;
            r = '{default: 0};
            cols = lim(gx, MAX_COLS);
            rows = lim(gy, MAX_ROWS);
            if (op == OP_WRITE) begin
                walk[d[4:0] * MAX_ROWS + d[9:5]] = d[10];
            end else if (op == OP_SEARCH) begin
                if (!run_search(axis_cell(d[42:11], ox, cols) * MAX_ROWS +
                                axis_cell(d[74:43], oy, rows),
                                axis_cell(d[106:75], ox, cols) * MAX_ROWS +
                                axis_cell(d[138:107], oy, rows), cols, rows))
                    r.status = ST_NO_PATH;
            end else if (op == OP_READ) begin
                if (d[148:139] < path.size()) begin
                    c = path[d[148:139]];
                    r.wx = ox + (c / MAX_ROWS) * ns;
                    r.wy = oy + (c % MAX_ROWS) * ns;
                    r.wz = oz;
                end else begin
                    r.status = ST_RANGE;
                end
            end
            r.path_len = 11'(path.size());
            pending.push_back(r);
        endfunction

        // check a result beat against the oldest expectation
        function void check_result(logic [1:0] st, logic [OUT_DATA_W-1:0] d);
            t_res e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result status=%0d data=%h", $realtime, st, d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status || d[10:0] !== e.path_len || d[42:11] !== e.wx ||
                d[74:43] !== e.wy || d[106:75] !== e.wz) begin
                $display("%0t: mismatch exp st=%0d len=%0d x=%h y=%h z=%h",
                         $realtime, e.status, e.path_len, e.wx, e.wy, e.wz);
                $display("%0t:          act st=%0d len=%0d x=%h y=%h z=%h",
                         $realtime, st, d[10:0], d[42:11], d[74:43], d[106:75]);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 0, i_rst_n = 0;
    logic                  s_axis_tvalid = 0, s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid, m_axis_tready = 0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  psel = 0, penable = 0, pwrite = 0;
    logic [4:0]            paddr = '0;
    logic [31:0]           pwdata = '0, prdata;
    logic                  pready;

    path_board board = new();
    int  send_idle = 35, recv_idle = 86;
    longint cycles = 0;

    grid_astar_path_search i_dut (.*);

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 40000000) begin
            $display("grid_astar_path_search verification failed");
            $finish;
        end
    end

    // receiver: random stall, check on handshake
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tuser, m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] v);
        psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        board.set_reg(idx, v);
        @(posedge i_clk);
    endtask

    // one input beat, with random idle cycles ahead of it
    task automatic send(logic [1:0] op, logic [IN_DATA_W-1:0] d);
        while ($urandom_range(99) < send_idle) @(posedge i_clk);
        s_axis_tvalid <= 1; s_axis_tuser <= op; s_axis_tdata <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_item(op, d);
        s_axis_tvalid <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic [IN_DATA_W-1:0] pack(logic [4:0] col, logic [4:0] row,
            logic w, logic [31:0] sx, logic [31:0] sy, logic [31:0] tx,
            logic [31:0] ty, logic [9:0] idx);
        return {3'b0, idx, ty, tx, sy, sx, w, row, col};
    endfunction

    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic search(int sc, int sr, int tc, int tr);
        logic [31:0] n;
        n = (board.ns == 0) ? 1 : board.ns;
        send(OP_SEARCH, pack(0, 0, 0, board.ox + sc * n, board.oy + sr * n,
                             board.ox + tc * n, board.oy + tr * n, 0));
    endtask

    task automatic read_path();
        for (int k = 0; k <= board.path.size() && k < 6; k++)
            send(OP_READ, pack(0, 0, 0, 0, 0, 0, 0, 10'(k)));
    endtask

    // random phase: mostly wall edits, searches and reads of the stored path
    task automatic random_phase(int n, int cmax, int rmax);
        logic [IN_DATA_W-1:0] d;
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(9);
            d = IN_DATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
            d[151:149] = 0;
            if (k < 4) begin
                d[4:0] = 5'($urandom_range(cmax)); d[9:5] = 5'($urandom_range(rmax));
                d[10] = ($urandom_range(3) != 0);
                send(OP_WRITE, d);
            end else if (k < 6) begin
                search($urandom_range(cmax), $urandom_range(rmax),
                       $urandom_range(cmax), $urandom_range(rmax));
            end else if (k == 6) begin
                send(OP_SEARCH, d);
            end else if (k == 7) begin
                send(OP_READ, pack(0, 0, 0, 0, 0, 0, 0,
                                   10'($urandom_range(board.path.size()))));
            end else begin
                send(k == 8 ? OP_READ : OP_IGNORE, d);
            end
        end
    endtask

    initial begin
        board.init();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // small grid for the directed part
        reg_write(REG_GRID_X, 8);
        reg_write(REG_GRID_Y, 6);
        reg_write(REG_NODE, 10);
        reg_write(REG_ORIGIN_X, -50);
        reg_write(REG_ORIGIN_Y, 25);
        reg_write(REG_ORIGIN_Z, 32'h7fff_ffff);
        search(0, 0, 7, 5);
        read_path();
        search(3, 3, 3, 3);                       // start equals target
        send(OP_READ, pack(0, 0, 0, 0, 0, 0, 0, 10'h3ff));
        for (int r = 0; r < 5; r++)
            send(OP_WRITE, pack(4, 5'(r), 0, 0, 0, 0, 0, 0));
        search(0, 2, 7, 2);                       // detour round a wall
        read_path();
        send(OP_WRITE, pack(4, 5, 0, 0, 0, 0, 0, 0));
        search(0, 2, 7, 2);                       // wall closed: no path
        send(OP_WRITE, pack(0, 2, 0, 0, 0, 0, 0, 0));
        send(OP_WRITE, pack(31, 31, 1, 0, 0, 0, 0, 0));
        send(OP_SEARCH, pack(0, 0, 0, 32'h8000_0000, 32'h7fff_ffff,
                             32'h7fff_ffff, 32'h8000_0000, 0));
        send(OP_IGNORE, '1);
        send(OP_WRITE, pack(1, 1, 0, 0, 0, 0, 0, 0));
        search(0, 0, 1, 1);                       // unwalkable target
        send(OP_WRITE, pack(1, 1, 1, 0, 0, 0, 0, 0));
        search(0, 2, 1, 2);                       // unwalkable start still expands
        send(OP_WRITE, pack(0, 2, 1, 0, 0, 0, 0, 0));
        drain();

        // zero sizes and node size, then extremes
        reg_write(REG_GRID_X, 0);
        reg_write(REG_GRID_Y, 0);
        reg_write(REG_NODE, 0);
        search(0, 0, 5, 5);
        send(OP_READ, pack(0, 0, 0, 0, 0, 0, 0, 0));
        drain();
        reg_write(REG_GRID_X, 63);
        reg_write(REG_GRID_Y, 63);
        reg_write(REG_NODE, 4095);
        reg_write(REG_ORIGIN_X, 32'h8000_0000);
        reg_write(REG_ORIGIN_Y, 32'h7fff_ffff);
        reg_write(REG_ORIGIN_Z, 32'h8000_0000);
        search(0, 0, 31, 31);
        send(OP_READ, pack(0, 0, 0, 0, 0, 0, 0, 30));
        send(OP_READ, pack(0, 0, 0, 0, 0, 0, 0, 31));
        // sender holds off until all results are back
        drain();

        // random phases on small grids
        reg_write(REG_GRID_X, 10);
        reg_write(REG_GRID_Y, 9);
        reg_write(REG_NODE, $urandom_range(1, 300));
        reg_write(REG_ORIGIN_X, $urandom);
        reg_write(REG_ORIGIN_Y, $urandom);
        reg_write(REG_ORIGIN_Z, $urandom);
        random_phase(35, 9, 8);
        drain();
        send_idle = 86; recv_idle = 35;
        reg_write(REG_GRID_X, 12);
        reg_write(REG_GRID_Y, 7);
        reg_write(REG_NODE, 1);
        random_phase(35, 11, 6);
        drain();
        send_idle = 0; recv_idle = 0;
        reg_write(REG_GRID_X, 32);
        reg_write(REG_GRID_Y, 4);
        reg_write(REG_NODE, 7);
        random_phase(35, 31, 3);
        drain();

        if (board.errors == 0)
            $display("grid_astar_path_search verification clean");
        else
            $display("grid_astar_path_search verification failed");
        $finish;
    end
endmodule
